@@ src/kfi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfi_pkg
// shared types, sizes and codes of the keyframe interpolator
// ----------------------------------------------------------------------------
package kfi_pkg;

  localparam int MAX_KEYS    = 64;
  localparam int KEY_AW      = $clog2(MAX_KEYS);
  localparam int NCNT_W      = $clog2(MAX_KEYS + 1);
  localparam int KCFG_W      = 7;
  localparam int IDX_W       = 6;
  localparam int TIME_W      = 32;
  localparam int VAL_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int FRAC_W      = 16;
  localparam int DSR_W       = TIME_W + 1;
  localparam int DIV_W       = DSR_W + FRAC_W;
  localparam int CHUNK_W     = 17;
  localparam int PP_W        = DSR_W + CHUNK_W;
  localparam int PROD_W      = DSR_W + DIV_W;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY_ONE,
    OP_QUERY_SEARCH,
    OP_DROP
  } op_t;

  typedef logic [2:0][VAL_W-1:0] vec3_t;

  typedef struct packed {
    op_t                op;
    logic [NCNT_W-1:0]  n_keys;
    logic [KEY_AW-1:0]  addr;
    logic [TIME_W-1:0]  key_time;
    vec3_t              key_val;
    logic [TIME_W-1:0]  query_time;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FETCH0,
    BK_FETCH1,
    BK_FETCH2,
    BK_CHECK,
    BK_DIV,
    BK_PREP,
    BK_MUL,
    BK_FIN,
    BK_OUT
  } bk_state_t;

endpackage

@@ src/vec3_keyframe_interpolator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_keyframe_interpolator_core
// keyframe table with linear interpolation of 3-component values
// ----------------------------------------------------------------------------
// items enter on in_valid / in_stall: kind 0 loads key_index with key_time
// and key_x/y/z and gives no result, kind 1 samples the table at query_time.
// each query gives one result on out_valid / out_stall: out_x/y/z and status
// (ok, zero-length segment, or saturated).
// key_count_we writes key_count, the number of keys in use; write it only
// while no item is in flight.
// a load passes through the input register and the queue before it is
// written into the key table. a query with one key in use reads that key
// and raises out_valid with its value; otherwise the linear walk over the
// key table (one entry per cycle on its read port) finds the segment, and
// unless it has zero length the serial divider forms the factor and three
// component steps, each with a 4-step partial-product multiply, form the
// result. the back end takes the next item once its result is in the
// output register.
// a two-entry queue lets the input side take items while a query runs.
// reset (rst, synchronous) empties the queue, drops any result and sets the
// key count to one; the key table is not cleared.
// a stalled result holds on the outputs; the back end finishes at most one
// more query and waits, with up to three more items held in front of it.
// ----------------------------------------------------------------------------
module vec3_keyframe_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [0:0]                    kind,
  input  logic [kfi_pkg::IDX_W-1:0]     key_index,
  input  logic [kfi_pkg::TIME_W-1:0]    key_time,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_x,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_y,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_z,
  input  logic [kfi_pkg::TIME_W-1:0]    query_time,
  input  logic                          key_count_we,
  input  logic [kfi_pkg::KCFG_W-1:0]    key_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [kfi_pkg::VAL_W-1:0] out_x,
  output logic signed [kfi_pkg::VAL_W-1:0] out_y,
  output logic signed [kfi_pkg::VAL_W-1:0] out_z,
  output logic [1:0]                    status
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  kfi_pkg::job_t     push_job;
  kfi_pkg::job_t     q_head;
  kfi_pkg::div_req_t div_req;
  kfi_pkg::div_rsp_t div_rsp;

  kfi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .key_index    (key_index),
    .key_time     (key_time),
    .key_x        (key_x),
    .key_y        (key_y),
    .key_z        (key_z),
    .query_time   (query_time),
    .key_count_we (key_count_we),
    .key_count    (key_count),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  kfi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  kfi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kfi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .status    (status)
  );

endmodule

@@ src/kfi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfi_front
// input register, key count register and item classification
// ----------------------------------------------------------------------------
module kfi_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [0:0]                    kind,
  input  logic [kfi_pkg::IDX_W-1:0]     key_index,
  input  logic [kfi_pkg::TIME_W-1:0]    key_time,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_x,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_y,
  input  logic signed [kfi_pkg::VAL_W-1:0] key_z,
  input  logic [kfi_pkg::TIME_W-1:0]    query_time,
  input  logic                          key_count_we,
  input  logic [kfi_pkg::KCFG_W-1:0]    key_count,
  input  logic                          q_full,
  output logic                          push,
  output kfi_pkg::job_t                 push_job
);

  logic [kfi_pkg::KCFG_W-1:0] keys_in_use;
  logic [kfi_pkg::NCNT_W-1:0] n_eff;
  logic                       job_valid;
  kfi_pkg::job_t              job;
  kfi_pkg::job_t              job_next;
  logic                       accept;

  always_comb begin
    if (keys_in_use == '0) begin
      n_eff = kfi_pkg::NCNT_W'(1);
    end else if (int'(keys_in_use) > kfi_pkg::MAX_KEYS) begin
      n_eff = kfi_pkg::NCNT_W'(kfi_pkg::MAX_KEYS);
    end else begin
      n_eff = kfi_pkg::NCNT_W'(keys_in_use);
    end
  end

  always_comb begin
    job_next.n_keys     = n_eff;
    job_next.addr       = kfi_pkg::KEY_AW'(key_index);
    job_next.key_time   = key_time;
    job_next.key_val    = {key_z, key_y, key_x};
    job_next.query_time = query_time;
    if (kind == 1'b0) begin
      job_next.op = (int'(key_index) < kfi_pkg::MAX_KEYS) ? kfi_pkg::OP_LOAD : kfi_pkg::OP_DROP;
    end else begin
      job_next.op = (n_eff == kfi_pkg::NCNT_W'(1)) ? kfi_pkg::OP_QUERY_ONE
                                                    : kfi_pkg::OP_QUERY_SEARCH;
    end
  end

  assign in_stall = job_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = job_valid && !q_full && (job.op != kfi_pkg::OP_DROP);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      keys_in_use <= kfi_pkg::KCFG_W'(1);
    end else begin
      if (key_count_we) begin
        keys_in_use <= key_count;
      end
      if (accept) begin
        job_valid <= 1'b1;
      end else if (job_valid && !q_full) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

@@ src/kfi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfi_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module kfi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kfi_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output kfi_pkg::job_t head
);

  localparam int PW = (kfi_pkg::QUEUE_DEPTH > 1) ? $clog2(kfi_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(kfi_pkg::QUEUE_DEPTH + 1);

  kfi_pkg::job_t   slots [kfi_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full  = (fill == CW'(kfi_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(kfi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(kfi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ src/kfi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfi_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kfi_div (
  input  logic              clk,
  input  logic              rst,
  input  kfi_pkg::div_req_t req,
  output kfi_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(kfi_pkg::DIV_W);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [kfi_pkg::DSR_W-1:0]   rem;
  logic [kfi_pkg::DSR_W-1:0]   dsr;
  logic [kfi_pkg::DIV_W-1:0]   dvd;
  logic [kfi_pkg::DIV_W-1:0]   quo;
  logic [kfi_pkg::DSR_W:0]     trial;
  logic [kfi_pkg::DSR_W:0]     trial_sub;
  logic                        fits;

  assign trial     = {rem, dvd[kfi_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(kfi_pkg::DIV_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      dsr <= req.divisor;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      dvd <= {dvd[kfi_pkg::DIV_W-2:0], 1'b0};
      if (fits) begin
        rem <= trial_sub[kfi_pkg::DSR_W-1:0];
        quo <= {quo[kfi_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[kfi_pkg::DSR_W-1:0];
        quo <= {quo[kfi_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/kfi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfi_back
// key table, segment search, interpolation sequencer and result register
// ----------------------------------------------------------------------------
module kfi_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  kfi_pkg::job_t                 q_head,
  output logic                          pop,
  output kfi_pkg::div_req_t             div_req,
  input  kfi_pkg::div_rsp_t             div_rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [kfi_pkg::VAL_W-1:0] out_x,
  output logic signed [kfi_pkg::VAL_W-1:0] out_y,
  output logic signed [kfi_pkg::VAL_W-1:0] out_z,
  output logic [1:0]                    status
);

  localparam int KAW  = kfi_pkg::KEY_AW;
  localparam int NW   = kfi_pkg::NCNT_W;
  localparam int DW   = kfi_pkg::DSR_W;
  localparam int VW   = kfi_pkg::VAL_W;
  localparam int CH   = kfi_pkg::CHUNK_W;
  localparam int MAGW = kfi_pkg::PROD_W - kfi_pkg::FRAC_W;
  localparam int RW   = 43;

  localparam logic signed [RW-1:0] R_MAX = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] R_MIN = -RW'(64'sd2147483648);

  kfi_pkg::bk_state_t state;
  kfi_pkg::bk_state_t state_next;

  logic [kfi_pkg::TIME_W-1:0] key_times [kfi_pkg::MAX_KEYS];
  kfi_pkg::vec3_t             key_vals  [kfi_pkg::MAX_KEYS];

  logic                       mem_we;
  logic [KAW-1:0]             rd_addr;
  logic [kfi_pkg::TIME_W-1:0] time_rd;
  kfi_pkg::vec3_t             val_rd;

  logic [kfi_pkg::TIME_W-1:0] qt;
  logic [NW-1:0]              n_keys;
  logic                       single;
  logic [NW-1:0]              scan_i;
  logic [NW-1:0]              cmp_i;
  logic                       cmp_v;
  logic [KAW-1:0]             seg;
  logic [kfi_pkg::TIME_W-1:0] t0;
  logic [kfi_pkg::TIME_W-1:0] t1;
  kfi_pkg::vec3_t             a_val;
  kfi_pkg::vec3_t             b_val;
  logic                       fneg;
  logic [kfi_pkg::DIV_W-1:0]  fm;
  logic [1:0]                 comp;
  logic [DW-1:0]              dmag;
  logic                       dneg;
  logic [1:0]                 mcnt;
  logic [kfi_pkg::PP_W-1:0]   pp;
  logic [kfi_pkg::PROD_W-1:0] acc;
  kfi_pkg::vec3_t             res;
  logic                       sat;
  logic [1:0]                 stat;

  logic                       hit;
  logic                       last;
  logic signed [DW-1:0]       span;
  logic signed [DW-1:0]       num;
  logic [DW-1:0]              smag;
  logic [DW-1:0]              nmag;
  logic                       div_start;
  logic                       out_load;
  logic signed [DW-1:0]       diff;
  logic [DW-1:0]              dabs;
  logic [CH-1:0]              chunk;
  logic [kfi_pkg::PP_W-1:0]   pp_next;
  logic [kfi_pkg::PROD_W-1:0] acc_next;
  logic [MAGW-1:0]            mag;
  logic                       big;
  logic                       rneg;
  logic signed [RW-1:0]       rsum;
  logic [VW-1:0]              res_c;
  logic                       sat_c;

  // search and segment arithmetic
  assign hit  = cmp_v && (qt < time_rd);
  assign last = cmp_v && (cmp_i == (n_keys - NW'(1)));
  assign span = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign num  = $signed({1'b0, qt}) - $signed({1'b0, t0});
  assign smag = span[DW-1] ? DW'(-span) : DW'(span);
  assign nmag = num[DW-1] ? DW'(-num) : DW'(num);

  assign div_req.start    = div_start;
  assign div_req.dividend = {nmag, {kfi_pkg::FRAC_W{1'b0}}};
  assign div_req.divisor  = smag;

  // per component difference and partial products
  assign diff = $signed({b_val[comp][VW-1], b_val[comp]})
              - $signed({a_val[comp][VW-1], a_val[comp]});
  assign dabs = diff[DW-1] ? DW'(-diff) : DW'(diff);

  always_comb begin
    unique case (mcnt)
      2'd0:    chunk = fm[CH-1:0];
      2'd1:    chunk = fm[2*CH-1:CH];
      2'd2:    chunk = CH'(fm[kfi_pkg::DIV_W-1:2*CH]);
      default: chunk = '0;
    endcase
  end

  assign pp_next = kfi_pkg::PP_W'(dmag) * kfi_pkg::PP_W'(chunk);

  always_comb begin
    unique case (mcnt)
      2'd0:    acc_next = '0;
      2'd1:    acc_next = acc + kfi_pkg::PROD_W'(pp);
      2'd2:    acc_next = acc + (kfi_pkg::PROD_W'(pp) << CH);
      default: acc_next = acc + (kfi_pkg::PROD_W'(pp) << (2 * CH));
    endcase
  end

  // scale, add and clamp one component
  assign mag  = acc[kfi_pkg::PROD_W-1:kfi_pkg::FRAC_W];
  assign big  = (|mag[MAGW-1:41]) || (mag[40] && (|mag[39:0]));
  assign rneg = dneg ^ fneg;
  assign rsum = $signed(RW'($signed(a_val[comp])))
              + (rneg ? -$signed({2'b00, mag[40:0]}) : $signed({2'b00, mag[40:0]}));

  always_comb begin
    sat_c = 1'b1;
    if (big) begin
      res_c = rneg ? VW'(R_MIN) : VW'(R_MAX);
    end else if (rsum > R_MAX) begin
      res_c = VW'(R_MAX);
    end else if (rsum < R_MIN) begin
      res_c = VW'(R_MIN);
    end else begin
      res_c = rsum[VW-1:0];
      sat_c = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kfi_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.op)
            kfi_pkg::OP_QUERY_ONE:    state_next = kfi_pkg::BK_FETCH0;
            kfi_pkg::OP_QUERY_SEARCH: state_next = kfi_pkg::BK_SCAN;
            default:                  state_next = kfi_pkg::BK_IDLE;
          endcase
        end
      end
      kfi_pkg::BK_SCAN: begin
        if (hit || last) begin
          state_next = kfi_pkg::BK_FETCH0;
        end
      end
      kfi_pkg::BK_FETCH0: state_next = kfi_pkg::BK_FETCH1;
      kfi_pkg::BK_FETCH1: state_next = kfi_pkg::BK_FETCH2;
      kfi_pkg::BK_FETCH2: state_next = kfi_pkg::BK_CHECK;
      kfi_pkg::BK_CHECK: begin
        if (single || (span == '0)) begin
          state_next = kfi_pkg::BK_OUT;
        end else begin
          state_next = kfi_pkg::BK_DIV;
        end
      end
      kfi_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_next = kfi_pkg::BK_PREP;
        end
      end
      kfi_pkg::BK_PREP: state_next = kfi_pkg::BK_MUL;
      kfi_pkg::BK_MUL: begin
        if (mcnt == 2'd3) begin
          state_next = kfi_pkg::BK_FIN;
        end
      end
      kfi_pkg::BK_FIN: begin
        state_next = (comp == 2'd2) ? kfi_pkg::BK_OUT : kfi_pkg::BK_PREP;
      end
      kfi_pkg::BK_OUT: begin
        if (!out_valid) begin
          state_next = kfi_pkg::BK_IDLE;
        end
      end
      default: state_next = kfi_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == kfi_pkg::BK_IDLE) && !q_empty;
    mem_we    = pop && (q_head.op == kfi_pkg::OP_LOAD);
    div_start = (state == kfi_pkg::BK_CHECK) && !single && (span != '0);
    out_load  = (state == kfi_pkg::BK_OUT) && !out_valid;
    unique case (state)
      kfi_pkg::BK_SCAN:   rd_addr = scan_i[KAW-1:0];
      kfi_pkg::BK_FETCH1: rd_addr = seg + KAW'(1);
      default:            rd_addr = seg;
    endcase
  end

  // key table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_times[q_head.addr] <= q_head.key_time;
      key_vals[q_head.addr]  <= q_head.key_val;
    end
    time_rd <= key_times[rd_addr];
    val_rd  <= key_vals[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kfi_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      kfi_pkg::BK_IDLE: begin
        qt     <= q_head.query_time;
        n_keys <= q_head.n_keys;
        single <= (q_head.op == kfi_pkg::OP_QUERY_ONE);
        seg    <= '0;
        scan_i <= NW'(1);
        cmp_i  <= '0;
        cmp_v  <= 1'b0;
      end
      kfi_pkg::BK_SCAN: begin
        scan_i <= scan_i + NW'(1);
        cmp_i  <= scan_i;
        cmp_v  <= 1'b1;
        if (hit) begin
          seg <= KAW'(cmp_i - NW'(1));
        end else if (last) begin
          seg <= KAW'(n_keys - NW'(2));
        end
      end
      kfi_pkg::BK_FETCH1: begin
        t0    <= time_rd;
        a_val <= val_rd;
      end
      kfi_pkg::BK_FETCH2: begin
        t1    <= time_rd;
        b_val <= val_rd;
      end
      kfi_pkg::BK_CHECK: begin
        res  <= a_val;
        fneg <= num[DW-1] ^ span[DW-1];
        stat <= (!single && (span == '0)) ? kfi_pkg::ST_ZERO_SPAN : kfi_pkg::ST_OK;
      end
      kfi_pkg::BK_DIV: begin
        fm   <= div_rsp.quotient;
        comp <= 2'd0;
        sat  <= 1'b0;
      end
      kfi_pkg::BK_PREP: begin
        dmag <= dabs;
        dneg <= diff[DW-1];
        mcnt <= 2'd0;
      end
      kfi_pkg::BK_MUL: begin
        pp   <= pp_next;
        acc  <= acc_next;
        mcnt <= mcnt + 2'd1;
      end
      kfi_pkg::BK_FIN: begin
        res[comp] <= res_c;
        sat       <= sat | sat_c;
        comp      <= comp + 2'd1;
        if (comp == 2'd2) begin
          stat <= (sat | sat_c) ? kfi_pkg::ST_SAT : kfi_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x  <= res[0];
      out_y  <= res[1];
      out_z  <= res[2];
      status <= stat;
    end
  end

endmodule
